// File: rtl/rft_pkg.sv
// ----------------------------------------------------------------------------
// rft_pkg
// shared types and constants for the rail fence transposer
// ----------------------------------------------------------------------------
`default_nettype none

package rft_pkg;

    localparam int BYTE_W   = 8;
    localparam int ROW_W    = 8;
    localparam int STRIDE_W = ROW_W + 1;

    localparam logic [ROW_W-1:0] ROWS_RESET = 8'd3;

    typedef struct packed {
        logic [BYTE_W-1:0] in_byte;
        logic              in_last;
    } in_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              out_last;
        logic              overflow;
    } out_t;

endpackage

`default_nettype wire

// File: rtl/rail_fence_transposer.sv
// ----------------------------------------------------------------------------
// rail_fence_transposer
// buffers a block of byte words and replays it in zigzag row order
// ----------------------------------------------------------------------------
// Usage: input words (in_data) arrive on a valid/ready channel, one byte each.
// Words are written into the block buffer, one per cycle, until a word with
// in_last set. Bytes past BLOCK_DEPTH are dropped and flagged in overflow.
// The last word starts the replay; in_ready stays low until the final result
// word (out_last) has been taken on the out_data valid/ready channel.
// A shared adder walks the zigzag index pattern: each result word passes an
// index check (ST_CAND) and an output state (ST_OUT), each stride advance adds
// an ST_ADV step, and each index past the block end adds another index check.
// Loading runs at one word per cycle. row_count of zero discards the block in
// the cycle the last word is taken; one row replays it unchanged.
// row_count is written through cfg_wr_en/cfg_wr_data; the user must write it only while idle (not enforced).
// Reset clears the fill count, the overflow flag and the sequencer, and sets
// row_count to 3. A stalled receiver simply holds the current result word;
// the sequencer waits with it.
// ----------------------------------------------------------------------------
`default_nettype none

module rail_fence_transposer #(
    parameter int BLOCK_DEPTH = 64
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_wr_en,
    input  wire logic [rft_pkg::ROW_W-1:0] cfg_wr_data,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire rft_pkg::in_t              in_data,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output rft_pkg::out_t                  out_data
);

    import rft_pkg::*;

    localparam int AW = $clog2(BLOCK_DEPTH);
    localparam int LW = $clog2(BLOCK_DEPTH + 1);
    localparam int CW = LW + STRIDE_W + 1;

    typedef enum logic [3:0] {
        ST_LOAD = 4'b0001,
        ST_CAND = 4'b0010,
        ST_OUT  = 4'b0100,
        ST_ADV  = 4'b1000
    } state_t;

    state_t                state_reg, state_next;
    logic [ROW_W-1:0]      rows_reg, rows_next;
    logic [LW-1:0]         fill_reg, fill_next;
    logic                  drop_reg, drop_next;
    logic [LW-1:0]         len_reg, len_next;
    logic [LW-1:0]         cnt_reg, cnt_next;
    logic [LW-1:0]         j_reg, j_next;
    logic [ROW_W-1:0]      r_reg, r_next;
    logic [STRIDE_W-1:0]   pmr_reg, pmr_next;
    logic [STRIDE_W-1:0]   stride_reg, stride_next;
    logic                  phase_reg, phase_next;

    logic [BYTE_W-1:0]     mem [BLOCK_DEPTH];
    logic [BYTE_W-1:0]     rd_data_reg;

    logic                  in_fire;
    logic                  wr_en;
    logic                  rd_en;
    logic [CW-1:0]         add_b;
    logic [CW-1:0]         sum;
    logic                  sum_in;
    logic                  middle;
    logic [LW-1:0]         fill_after;
    logic [STRIDE_W-1:0]   stride_new;

    assign in_ready  = (state_reg == ST_LOAD);
    assign out_valid = (state_reg == ST_OUT);
    assign in_fire   = in_valid && in_ready;
    assign wr_en     = in_fire && (fill_reg != LW'(BLOCK_DEPTH));
    assign fill_after = wr_en ? LW'(fill_reg + LW'(1)) : fill_reg;

    assign out_data.out_byte = rd_data_reg;
    assign out_data.out_last = (LW'(cnt_reg + LW'(1)) == len_reg);
    assign out_data.overflow = drop_reg;

    assign middle = (r_reg != '0) && (r_reg != ROW_W'(rows_reg - ROW_W'(1)));
    assign stride_new = (rows_reg == ROW_W'(1)) ? STRIDE_W'(1)
                      : STRIDE_W'({rows_reg, 1'b0} - STRIDE_W'(2));

    // shared index adder
    always_comb
    begin
        if (state_reg == ST_ADV)
        begin
            add_b = CW'(stride_reg);
        end
        else if (phase_reg)
        begin
            add_b = CW'(pmr_reg);
        end
        else
        begin
            add_b = CW'(r_reg);
        end
    end

    assign sum    = CW'(j_reg) + add_b;
    assign sum_in = (sum < CW'(len_reg));
    assign rd_en  = (state_reg == ST_CAND) && sum_in;

    always_comb
    begin
        state_next  = state_reg;
        rows_next   = rows_reg;
        fill_next   = fill_reg;
        drop_next   = drop_reg;
        len_next    = len_reg;
        cnt_next    = cnt_reg;
        j_next      = j_reg;
        r_next      = r_reg;
        pmr_next    = pmr_reg;
        stride_next = stride_reg;
        phase_next  = phase_reg;

        if (cfg_wr_en)
        begin
            rows_next = cfg_wr_data;
        end

        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_fire)
                begin
                    fill_next = fill_after;
                    if (!wr_en)
                    begin
                        drop_next = 1'b1;
                    end
                    if (in_data.in_last)
                    begin
                        if (rows_reg == '0)
                        begin
                            fill_next = '0;
                            drop_next = 1'b0;
                        end
                        else
                        begin
                            len_next    = fill_after;
                            cnt_next    = '0;
                            j_next      = '0;
                            r_next      = '0;
                            phase_next  = 1'b0;
                            stride_next = stride_new;
                            pmr_next    = stride_new;
                            state_next  = ST_CAND;
                        end
                    end
                end
            end
            ST_CAND:
            begin
                if (sum_in)
                begin
                    state_next = ST_OUT;
                end
                else if (!phase_reg && middle)
                begin
                    phase_next = 1'b1;
                end
                else
                begin
                    phase_next = 1'b0;
                    state_next = ST_ADV;
                end
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    if (out_data.out_last)
                    begin
                        fill_next  = '0;
                        drop_next  = 1'b0;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        cnt_next = LW'(cnt_reg + LW'(1));
                        if (!phase_reg && middle)
                        begin
                            phase_next = 1'b1;
                            state_next = ST_CAND;
                        end
                        else
                        begin
                            phase_next = 1'b0;
                            state_next = ST_ADV;
                        end
                    end
                end
            end
            ST_ADV:
            begin
                state_next = ST_CAND;
                if (sum_in)
                begin
                    j_next = sum[LW-1:0];
                end
                else
                begin
                    j_next   = '0;
                    r_next   = ROW_W'(r_reg + ROW_W'(1));
                    pmr_next = STRIDE_W'(pmr_reg - STRIDE_W'(1));
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_LOAD;
            rows_reg   <= ROWS_RESET;
            fill_reg   <= '0;
            drop_reg   <= 1'b0;
            len_reg    <= '0;
            cnt_reg    <= '0;
            j_reg      <= '0;
            r_reg      <= '0;
            pmr_reg    <= '0;
            stride_reg <= '0;
            phase_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rows_reg   <= rows_next;
            fill_reg   <= fill_next;
            drop_reg   <= drop_next;
            len_reg    <= len_next;
            cnt_reg    <= cnt_next;
            j_reg      <= j_next;
            r_reg      <= r_next;
            pmr_reg    <= pmr_next;
            stride_reg <= stride_next;
            phase_reg  <= phase_next;
        end
    end

    // block buffer, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[fill_reg[AW-1:0]] <= in_data.in_byte;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[sum[AW-1:0]];
        end
    end

endmodule

`default_nettype wire
